[hw/rtl/wall_angle_pi_controller_defines.svh]
// ============================================================================
// Wall angle PI controller assertion macros
// Shared helpers for the concurrent checks of the controller.
// ============================================================================
`ifndef WALL_ANGLE_PI_CONTROLLER_DEFINES_SVH
`define WALL_ANGLE_PI_CONTROLLER_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define WAPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define WAPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/wapc_pkg.sv]
// ============================================================================
// Wall angle PI controller package
// Types, constants and the CORDIC arctangent table shared by the block.
// ============================================================================
package wapc_pkg;

    localparam int TICK_MS_DEF      = 25;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    // Configuration register indexes.
    localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [2:0] REG_TARGET_ANGLE = 3'd2;
    localparam logic [2:0] REG_SIDE_X       = 3'd3;
    localparam logic [2:0] REG_FRONT_X      = 3'd4;
    localparam logic [2:0] REG_FRONT_Y      = 3'd5;

    localparam logic [15:0] PROP_GAIN_RST  = 16'd1638;
    localparam logic [15:0] INTEG_GAIN_RST = 16'd41;

    localparam logic [16:0]        COS45_Q16    = 17'd46341;
    localparam logic signed [26:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [30:0] INTEG_LIMIT  = 31'sd65280000;
    localparam logic signed [17:0] ANGLE_LIMIT  = 18'sd23040;
    localparam logic [12:0]        DIST_MIN     = 13'd5;
    localparam logic [12:0]        DIST_MAX     = 13'd200;
    localparam logic signed [10:0] OUT_SCALE    = 11'sd1000;
    localparam logic [24:0]        OUT_RECIP    = 25'd17179869;

    typedef struct packed {
        logic [12:0] side_distance;
        logic        side_ok;
        logic [12:0] diag_distance;
        logic        diag_ok;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] correction;
        logic               correction_ok;
        logic signed [15:0] wall_angle;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREROT, ST_STEP, ST_ROUND, ST_ERR, ST_MUL1, ST_MUL2,
        ST_MUL3, ST_SUM, ST_ABS, ST_DIV1, ST_DIV2, ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_PREROT, OP_STEP, OP_ROUND, OP_ERR, OP_MUL1,
        OP_MUL2, OP_MUL3, OP_SUM, OP_ABS, OP_DIV1, OP_DIV2, OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic in_range;
    } dp_status_t;

    // atan(2^-i) in 1/65536 degree.
    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/wapc_dp.sv]
// ============================================================================
// Wall angle PI controller datapath
// Configuration registers, CORDIC vectoring unit, PI arithmetic and output.
// ============================================================================
module wapc_dp
    import wapc_pkg::*;
#(
    parameter int TICK_MS = TICK_MS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  in_word_t   in_word,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_word_t  out_word
);

    localparam logic signed [10:0] TICK_S = 11'(TICK_MS);

    logic [15:0]        kp_reg, ki_reg;
    logic signed [15:0] target_reg;
    logic signed [10:0] sx_reg, fx_reg, fy_reg;
    logic signed [27:0] integral_reg;
    logic               done_reg;

    logic signed [31:0] x_reg, y_reg;
    logic signed [26:0] z_reg;
    logic               zero_reg;
    logic signed [17:0] a_reg;
    logic signed [18:0] err_reg;
    logic signed [35:0] p1_reg;
    logic signed [29:0] p2_reg;
    logic signed [46:0] p1k_reg;
    logic signed [27:0] acc_reg;
    logic signed [44:0] p3_reg;
    logic signed [47:0] s_reg;
    logic               sneg_reg;
    logic [23:0]        m_reg;
    logic [14:0]        q0_reg;
    logic signed [15:0] corr_reg;
    out_word_t          out_word_reg;

    logic               usable;
    logic [29:0]        d2m;
    logic signed [13:0] side_sum;
    logic signed [31:0] x0, y0, xs, ys;
    logic [26:0]        z_mag, z_rnd;
    logic signed [17:0] a_val;
    logic               in_range;
    logic signed [30:0] acc_sum, acc_clamp;
    logic [47:0]        s_mag;
    logic [48:0]        prod;
    logic [24:0]        rem;
    logic [15:0]        q;

    always_comb
    begin
        usable = in_word.side_ok && in_word.diag_ok
              && (in_word.side_distance > DIST_MIN) && (in_word.diag_distance > DIST_MIN)
              && (in_word.side_distance <= DIST_MAX) && (in_word.diag_distance <= DIST_MAX);
        d2m      = 30'(in_word.diag_distance) * 30'(COS45_Q16);
        side_sum = 14'(sx_reg) + $signed({1'b0, in_word.side_distance});
        x0 = (32'(fy_reg) <<< 16) + $signed({2'b0, d2m});
        y0 = (32'(fx_reg) <<< 16) + $signed({2'b0, d2m}) - (32'(side_sum) <<< 16);

        xs = x_reg >>> cmd.step;
        ys = y_reg >>> cmd.step;

        z_mag = z_reg[26] ? 27'(-z_reg) : 27'(z_reg);
        z_rnd = z_mag + 27'd128;
        if (zero_reg)
            a_val = '0;
        else if (z_reg[26])
            a_val = -$signed({1'b0, z_rnd[24:8]});
        else
            a_val = $signed({1'b0, z_rnd[24:8]});

        in_range = (a_reg < ANGLE_LIMIT) && (a_reg > -ANGLE_LIMIT);

        acc_sum = 31'(integral_reg) + 31'(p2_reg);
        if (acc_sum > INTEG_LIMIT)
            acc_clamp = INTEG_LIMIT;
        else if (acc_sum < -INTEG_LIMIT)
            acc_clamp = -INTEG_LIMIT;
        else
            acc_clamp = acc_sum;

        s_mag = s_reg[47] ? 48'(-s_reg) : 48'(s_reg);
        prod  = 49'(m_reg) * 49'(OUT_RECIP);
        rem   = {1'b0, m_reg} - 25'(q0_reg) * 25'(OUT_SCALE);
        q     = (rem >= 25'(OUT_SCALE)) ? 16'(q0_reg) + 16'd1 : 16'(q0_reg);
    end

    // Configuration and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg       <= PROP_GAIN_RST;
            ki_reg       <= INTEG_GAIN_RST;
            target_reg   <= '0;
            sx_reg       <= '0;
            fx_reg       <= '0;
            fy_reg       <= '0;
            integral_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:    kp_reg     <= cfg_data;
                    REG_INTEG_GAIN:   ki_reg     <= cfg_data;
                    REG_TARGET_ANGLE: target_reg <= $signed(cfg_data);
                    REG_SIDE_X:       sx_reg     <= $signed(cfg_data[10:0]);
                    REG_FRONT_X:      fx_reg     <= $signed(cfg_data[10:0]);
                    REG_FRONT_Y:      fy_reg     <= $signed(cfg_data[10:0]);
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_LOAD:   done_reg     <= usable;
                OP_ERR:    done_reg     <= done_reg && in_range;
                OP_FINISH: integral_reg <= done_reg ? acc_reg : '0;
                default: ;
            endcase
        end
    end

    // Arithmetic registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                x_reg <= x0;
                y_reg <= y0;
            end
            OP_PREROT:
            begin
                zero_reg <= (x_reg == '0) && (y_reg == '0);
                if (x_reg[31])
                begin
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                    z_reg <= y_reg[31] ? -HALF_TURN : HALF_TURN;
                end
                else
                begin
                    z_reg <= '0;
                end
            end
            OP_STEP:
            begin
                if (!y_reg[31])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + $signed({5'b0, atan_q16(cmd.step)});
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - $signed({5'b0, atan_q16(cmd.step)});
                end
            end
            OP_ROUND: a_reg   <= a_val;
            OP_ERR:   err_reg <= 19'(target_reg) - 19'(a_reg);
            OP_MUL1:
            begin
                p1_reg <= err_reg * $signed({1'b0, kp_reg});
                p2_reg <= err_reg * TICK_S;
            end
            OP_MUL2:
            begin
                p1k_reg <= p1_reg * OUT_SCALE;
                acc_reg <= 28'(acc_clamp);
            end
            OP_MUL3: p3_reg <= acc_reg * $signed({1'b0, ki_reg});
            OP_SUM:  s_reg  <= 48'(p1k_reg) + 48'(p3_reg);
            OP_ABS:
            begin
                sneg_reg <= s_reg[47];
                m_reg    <= s_mag[43:20];
            end
            OP_DIV1: q0_reg <= prod[48:34];
            OP_DIV2: corr_reg <= sneg_reg ? -$signed(q) : $signed(q);
            OP_FINISH:
            begin
                out_word_reg.correction    <= done_reg ? corr_reg : '0;
                out_word_reg.correction_ok <= done_reg;
                out_word_reg.wall_angle    <= done_reg ? 16'(a_reg) : '0;
            end
            default: ;
        endcase
    end

    assign status.done     = done_reg;
    assign status.in_range = in_range;
    assign out_word        = out_word_reg;

endmodule

[hw/rtl/wapc_ctrl.sv]
// ============================================================================
// Wall angle PI controller sequencer
// Handshakes both channels and steps the datapath through one tick.
// ============================================================================
module wapc_ctrl
    import wapc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int CW = $clog2(CORDIC_STEPS);
    localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] step_reg, step_next;
    logic          out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NOP;
        cmd.step       = 5'(step_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_PREROT;
                end
            end
            ST_PREROT:
            begin
                cmd.op     = OP_PREROT;
                step_next  = '0;
                state_next = status.done ? ST_STEP : ST_FINISH;
            end
            ST_STEP:
            begin
                cmd.op = OP_STEP;
                if (step_reg == LAST_STEP)
                    state_next = ST_ROUND;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_ROUND:
            begin
                cmd.op     = OP_ROUND;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = (status.done && status.in_range) ? ST_MUL1 : ST_FINISH;
            end
            ST_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.op     = OP_MUL3;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.op     = OP_ABS;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.op     = OP_DIV1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.op     = OP_DIV2;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/wall_angle_pi_controller.sv]
// ============================================================================
// Wall angle PI controller
// Estimates the wall angle from two range readings and runs a PI step.
// ============================================================================
//
//   channel   direction  handshake            word
//   in        input      in_valid / in_stall   in_word_t (two ranges + flags)
//   out       output     out_valid / out_stall out_word_t (correction, angle)
//   cfg       input      cfg_write             cfg_index, cfg_data
//
// A usable tick runs from acceptance through the pre-rotation, the shared CORDIC
// rotator that runs one step per cycle, the rounding, error, multiply, sum,
// absolute value and divide states to the result register. A usable tick with a
// steep angle goes there after the error state, an unusable one after pre-rotation.
// Reset clears the integral, restores the gain defaults and empties the output.
// A result waits in the output register while out_stall is high; the next word
// is still accepted and held back only at its final write.
//
// Each accepted word carries a side reading and a 45-degree reading. When both
// are valid and inside 6..200 mm, the wall vector is built in mm with sixteen
// fraction bits and its angle is found by CORDIC vectoring in 1/65536 degree,
// then rounded to 1/256 degree. Angles within plus or minus 90 degrees feed a
// PI step whose integral is clamped to plus or minus 255 degree-seconds. The
// final scale by 1000 * 2^20 is a shift followed by a reciprocal multiply with
// a single correction step. Every other word clears the integral and reports a
// zero correction.
//
module wall_angle_pi_controller
    import wapc_pkg::*;
#(
    parameter int TICK_MS      = TICK_MS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The sequencer owns both handshakes and the step counter.
    wapc_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the registers, the rotator and the output word.
    wapc_dp #(
        .TICK_MS (TICK_MS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_word  (out_word)
    );

endmodule

[hw/rtl/wapc_checker.sv]
// ============================================================================
// Wall angle PI controller checker
// Port-level checks of the controller, attached to the top level by bind.
// ============================================================================
`include "wall_angle_pi_controller_defines.svh"

module wapc_checker
    import wapc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input out_word_t   out_word
);

    // A waiting result keeps its word until it is taken.
    `WAPC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "out word changed while stalled")

    // One word in flight: an accepted word closes the input for the next cycle.
    `WAPC_ASSERT(a_in_busy, in_valid && !in_stall |=> in_stall, "input accepted twice in a row")

    // A skipped tick reports nothing.
    `WAPC_ASSERT(a_skip_zero, out_valid && !out_word.correction_ok |-> out_word.correction == 16'sd0 && out_word.wall_angle == 16'sd0, "skipped tick has nonzero fields")

    // A computed correction only comes from an angle inside plus or minus 90 degrees.
    `WAPC_ASSERT(a_angle_range, out_valid && out_word.correction_ok |-> out_word.wall_angle < 16'sd23040 && out_word.wall_angle > -16'sd23040, "wall angle out of range")

endmodule

bind wall_angle_pi_controller wapc_checker u_wapc_checker (.*);

[tb/sv/tb.sv]
// ============================================================================
// Wall angle PI controller testbench
// Drives range words through the controller, predicts each correction with
// an independent fixed-point model and compares every result word in order.
// ============================================================================
module tb
    import wapc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK     = 25;
    localparam int STEPS    = 16;
    localparam int N_RANDOM = 850;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_word;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    wall_angle_pi_controller #(.TICK_MS(TICK), .CORDIC_STEPS(STEPS)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the register file and the integrator.
    logic [15:0] kp_q, ki_q, target_q;
    logic [10:0] side_x_q, front_x_q, front_y_q;
    longint      integ_acc;

    in_word_t  pending_ticks[$];
    out_word_t expected_words[$];
    int        mismatches = 0;
    bit        sender_hold = 1'b0;

    // CORDIC vectoring arctangent in 1/65536 degree, floor shifts.
    function automatic longint cordic_angle(longint y, longint x);
        longint z = 0;
        longint xs, ys;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z += longint'(atan_q16(5'(i)));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= longint'(atan_q16(5'(i)));
            end
        end
        return z;
    endfunction

    // Works out the result word of one tick and advances the integrator.
    function automatic out_word_t steer_tick(in_word_t w);
        out_word_t r = '0;
        longint d1, d2, x1, xf, yf, z, mag, a, err, acc, corr;
        d1 = w.side_distance;
        d2 = w.diag_distance;
        if (w.side_ok && w.diag_ok && d1 > 5 && d2 > 5 && d1 <= 200 && d2 <= 200)
        begin
            x1 = (longint'($signed(side_x_q)) + d1) * 65536;
            xf = longint'($signed(front_x_q)) * 65536 + d2 * 46341;
            yf = longint'($signed(front_y_q)) * 65536 + d2 * 46341;
            z = cordic_angle(xf - x1, yf);
            mag = (z < 0) ? -z : z;
            a = (mag + 128) / 256;
            if (z < 0)
                a = -a;
            if (a < 23040 && a > -23040)
            begin
                err = longint'($signed(target_q)) - a;
                acc = integ_acc + err * TICK;
                if (acc > 65280000)
                    acc = 65280000;
                if (acc < -65280000)
                    acc = -65280000;
                integ_acc = acc;
                corr = (err * longint'(kp_q) * 1000 + acc * longint'(ki_q)) / 1048576000;
                if (corr > 32767)
                    corr = 32767;
                if (corr < -32768)
                    corr = -32768;
                r.correction = 16'(corr);
                r.correction_ok = 1'b1;
                r.wall_angle = 16'(a);
                return r;
            end
        end
        integ_acc = 0;
        return r;
    endfunction

    bit took_word = 1'b0;
    bit stall_mode = 1'b0;
    int stall_phase = 0;

    // Driver: bursts of words with random gaps, valid held while stalled.
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || took_word)
            begin
                if (gap_left > 0 || sender_hold || pending_ticks.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    in_word <= pending_ticks.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 0);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
            // The receiver stalls in phases: free stretches, then random stalls.
            out_stall <= stall_mode ? ($urandom_range(2, 0) == 0) : 1'b0;
        end
    end

    // Monitor: accept the input word into the predictor and check results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_word = in_valid && !in_stall;
            if (took_word)
                expected_words.push_back(steer_tick(in_word));
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", out_word);
                end
                else
                begin
                    out_word_t e;
                    e = expected_words.pop_front();
                    if (e !== out_word)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp corr %0d ok %0d ang %0d, got %0d %0d %0d",
                                e.correction, e.correction_ok, e.wall_angle,
                                out_word.correction, out_word.correction_ok,
                                out_word.wall_angle);
                    end
                end
            end
            stall_phase++;
            if (stall_phase % 300 == 0)
                stall_mode = ~stall_mode;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_PROP_GAIN:    kp_q = val;
            REG_INTEG_GAIN:   ki_q = val;
            REG_TARGET_ANGLE: target_q = val;
            REG_SIDE_X:       side_x_q = val[10:0];
            REG_FRONT_X:      front_x_q = val[10:0];
            REG_FRONT_Y:      front_y_q = val[10:0];
            default: ;
        endcase
    endtask

    // Waits until every queued tick has been answered, plus drain margin.
    task automatic drain();
        while (pending_ticks.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic in_word_t make_tick(int d1, bit o1, int d2, bit o2);
        in_word_t w;
        w.side_distance = 13'(d1);
        w.side_ok = o1;
        w.diag_distance = 13'(d2);
        w.diag_ok = o2;
        return w;
    endfunction

    // Mostly usable readings, with some invalid or out-of-range noise.
    function automatic in_word_t random_tick();
        int sel = $urandom_range(9, 0);
        if (sel < 8)
            return make_tick($urandom_range(200, 6), 1'b1, $urandom_range(200, 6), 1'b1);
        return make_tick($urandom_range(8191, 0), 1'($urandom_range(1, 0)),
            $urandom_range(8191, 0), 1'($urandom_range(1, 0)));
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            pending_ticks.push_back(random_tick());
    endtask

    initial
    begin
        kp_q = PROP_GAIN_RST;
        ki_q = INTEG_GAIN_RST;
        target_q = '0;
        side_x_q = '0;
        front_x_q = '0;
        front_y_q = '0;
        integ_acc = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: distance limits, flags and steep angles.
        pending_ticks.push_back(make_tick(6, 1, 6, 1));
        pending_ticks.push_back(make_tick(5, 1, 100, 1));
        pending_ticks.push_back(make_tick(100, 1, 5, 1));
        pending_ticks.push_back(make_tick(200, 1, 200, 1));
        pending_ticks.push_back(make_tick(201, 1, 100, 1));
        pending_ticks.push_back(make_tick(100, 1, 201, 1));
        pending_ticks.push_back(make_tick(100, 0, 100, 1));
        pending_ticks.push_back(make_tick(100, 1, 100, 0));
        pending_ticks.push_back(make_tick(8191, 1, 8191, 1));
        pending_ticks.push_back(make_tick(0, 0, 0, 0));
        pending_ticks.push_back(make_tick(150, 1, 6, 1));
        pending_ticks.push_back(make_tick(6, 1, 200, 1));
        drain();
        // Negative offsets that pull the wall vector close to the origin.
        write_reg(REG_SIDE_X, 16'(-100));
        write_reg(REG_FRONT_Y, 16'(-65));
        write_reg(REG_FRONT_X, 16'(-65));
        pending_ticks.push_back(make_tick(100, 1, 92, 1));
        pending_ticks.push_back(make_tick(6, 1, 6, 1));
        pending_ticks.push_back(make_tick(200, 1, 100, 1));
        drain();

        // Random phases across register settings, extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_PROP_GAIN, (ph == 1) ? 16'hFFFF : (ph == 2) ? 16'h0 : 16'($urandom));
            write_reg(REG_INTEG_GAIN, (ph == 1) ? 16'hFFFF : (ph == 2) ? 16'h0 : 16'($urandom));
            write_reg(REG_TARGET_ANGLE, (ph == 1) ? 16'(23040) : (ph == 2) ? 16'(-23040)
                : (ph == 3) ? 16'h7FFF : 16'($urandom));
            write_reg(REG_SIDE_X, (ph == 1) ? 16'h3FF : (ph == 2) ? 16'h400
                : 16'($urandom_range(200, 0) - 100));
            write_reg(REG_FRONT_X, (ph == 1) ? 16'h3FF : (ph == 2) ? 16'h400
                : 16'($urandom_range(2047, 0)));
            write_reg(REG_FRONT_Y, (ph == 1) ? 16'h400 : (ph == 2) ? 16'h3FF
                : 16'($urandom_range(200, 0) - 100));
            write_reg(3'd7, 16'($urandom));
            run_random(N_RANDOM / 6);
            // Hold the sender until all results are in, then release it.
            if (ph == 3)
            begin
                while (pending_ticks.size() > 60)
                    @(posedge clk);
                sender_hold = 1'b1;
                while (in_valid || expected_words.size() != 0)
                    @(posedge clk);
                sender_hold = 1'b0;
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/wapc_pkg.sv
hw/rtl/wapc_dp.sv
hw/rtl/wapc_ctrl.sv
hw/rtl/wall_angle_pi_controller.sv
hw/rtl/wapc_checker.sv
tb/sv/tb.sv
